[rtl/core/cmap_pkg.sv]
package cmap_pkg;

    // Window geometry
    localparam int MAX_HALF = 8;
    localparam int WIN_MAX  = 2 * MAX_HALF + 1;
    localparam int WIN_AW   = $clog2(WIN_MAX);
    localparam int CNT_W    = $clog2(WIN_MAX + 1);

    // Sample and sum widths
    localparam int SMP_W    = 32;
    localparam int HW_W     = 4;
    localparam int SUM_W    = SMP_W + $clog2(WIN_MAX);

    // Divider: DIV_BITS quotient bits per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_EMIT,
        S_DUMP
    } t_state;

    // Control from the sequencer to each lane
    typedef struct packed {
        logic              push;      // write sample, update sum
        logic              full;      // window full: retire the oldest sample
        logic              clear;     // zero the running sum
        logic [WIN_AW-1:0] addr;      // window slot to write and read
        logic              div_load;  // latch |sum| into the divider
        logic              div_step;  // advance the divider
    } t_lane_ctl;

endpackage

[rtl/core/cmap_in_if.sv]
interface cmap_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_a;
    logic signed [31:0] sample_b;
    logic               run_end;

    modport source (output valid, output sample_a, output sample_b, output run_end,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input run_end,
                    output ready);
endinterface

[rtl/core/cmap_out_if.sv]
interface cmap_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] smooth_a;
    logic signed [31:0] smooth_b;
    logic               out_end;

    modport source (output valid, output smooth_a, output smooth_b, output out_end,
                    input ready);
    modport sink   (input valid, input smooth_a, input smooth_b, input out_end,
                    output ready);
endinterface

[rtl/core/cmap_lane.sv]
module cmap_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cmap_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [cmap_pkg::SMP_W-1:0]   i_sample,
    input  logic [cmap_pkg::CNT_W-1:0]          i_win,
    output logic signed [cmap_pkg::SMP_W-1:0]   o_avg,
    output logic signed [cmap_pkg::SMP_W-1:0]   o_rd_data
);
    import cmap_pkg::*;

    logic signed [SMP_W-1:0] r_win [WIN_MAX];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] w_add;
    logic signed [SUM_W-1:0] w_sub;
    logic [SUM_W-1:0]        w_mag;

    logic                    r_neg;
    logic [DIV_W-1:0]        r_num;
    logic [CNT_W-1:0]        r_rem;
    logic [DIV_W-1:0]        n_num;
    logic [CNT_W-1:0]        n_rem;
    logic [CNT_W:0]          w_part;
    logic [SMP_W-1:0]        w_quo;

    assign o_rd_data = r_win[i_ctl.addr];

    // Running sum: add the new sample, retire the overwritten one
    assign w_add = SUM_W'(i_sample);
    assign w_sub = i_ctl.full ? SUM_W'(o_rd_data) : '0;
    assign n_sum = r_sum + w_add - w_sub;
    assign w_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_win[i_ctl.addr] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.push) begin
            r_sum <= n_sum;
        end
    end

    // Restoring division of |sum| by the window length, DIV_BITS bits a cycle
    always_comb begin
        n_rem  = r_rem;
        n_num  = r_num;
        w_part = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_part = {n_rem, n_num[DIV_W-1]};
            n_num  = {n_num[DIV_W-2:0], 1'b0};
            if (w_part >= {1'b0, i_win}) begin
                n_rem    = CNT_W'(w_part - {1'b0, i_win});
                n_num[0] = 1'b1;
            end else begin
                n_rem = w_part[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_num <= DIV_W'(w_mag);
            r_rem <= '0;
        end else if (i_ctl.div_step) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    // Restore the sign: truncation toward zero
    assign w_quo = r_num[SMP_W-1:0];
    assign o_avg = r_neg ? SMP_W'(-w_quo) : SMP_W'(w_quo);

endmodule

[rtl/core/centered_moving_average_pair.sv]
// Centered boxcar smoother for two channels of signed Q16.16 samples. A run of
// sample pairs ends with run_end; each channel is averaged over W = 2h+1
// samples centered on each position, h taken from the 4-bit half-width
// register (values above 8 act as 8, reset value 4). The first h and last h
// positions repeat the first and last full-window average; a run shorter than
// W comes back unchanged. Averages are exact sums divided by W, truncated
// toward zero. Results leave in input order on the output channel, the last
// one of each run flagged with out_end. Sequence: an item that does not yet
// fill the window is only accepted into it; an item that produces an average
// is accepted, has its sum latched into the divider, runs through the divider
// (4 quotient bits per cycle over the 40-bit dividend) and then emits each
// result copy in turn. The input is not ready again until the item is done.
// A short run ending early flushes its held samples one at a time.
// Output stalls stretch the emit and flush phases only. Writing half-width
// drops any partial run without output; write it only while the block is idle.
module centered_moving_average_pair (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cmap_pkg::HW_W-1:0] i_cfg_data,
    cmap_in_if.sink                   i_in,
    cmap_out_if.source                o_out
);
    import cmap_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [HW_W-1:0]    r_hw;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;
    logic [WIN_AW-1:0]  r_wp;
    logic [WIN_AW-1:0]  n_wp;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [WIN_AW-1:0]  r_idx;
    logic [WIN_AW-1:0]  n_idx;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  n_step;
    logic               r_end;
    logic               n_end;

    // Output register: the merge stage that joins both lanes into one item
    logic               r_ov;
    logic [SMP_W-1:0]   r_oa;
    logic [SMP_W-1:0]   r_ob;
    logic               r_oend;
    logic               w_load;
    logic [SMP_W-1:0]   w_ld_a;
    logic [SMP_W-1:0]   w_ld_b;
    logic               w_ld_end;
    logic               w_out_free;

    logic [CNT_W-1:0]   w_h;
    logic [CNT_W-1:0]   w_w;
    logic [CNT_W-1:0]   w_fill_nx;
    logic [WIN_AW-1:0]  w_wp_nx;
    logic               w_full;

    t_lane_ctl          w_ctl;
    logic [SMP_W-1:0]   w_avg_a;
    logic [SMP_W-1:0]   w_avg_b;
    logic [SMP_W-1:0]   w_rd_a;
    logic [SMP_W-1:0]   w_rd_b;

    // Effective half width saturates at MAX_HALF
    assign w_h       = (r_hw > MAX_HALF) ? CNT_W'(MAX_HALF) : CNT_W'(r_hw);
    assign w_w       = {w_h[CNT_W-2:0], 1'b1};
    assign w_full    = (r_fill == w_w);
    assign w_fill_nx = r_fill + 1'b1;
    assign w_wp_nx   = (r_wp == WIN_AW'(w_w - 1'b1)) ? '0 : WIN_AW'(r_wp + 1'b1);

    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    cmap_lane u_lane_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_sample  (i_in.sample_a),
        .i_win     (w_w),
        .o_avg     (w_avg_a),
        .o_rd_data (w_rd_a)
    );

    cmap_lane u_lane_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_sample  (i_in.sample_b),
        .i_win     (w_w),
        .o_avg     (w_avg_b),
        .o_rd_data (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= HW_W'(4);
            r_fill  <= '0;
            r_wp    <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_step  <= '0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_wp    <= n_wp;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_end   <= n_end;
            if (i_cfg_we) begin
                r_hw <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_wp     = r_wp;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_step   = r_step;
        n_end    = r_end;
        w_ctl    = '0;
        w_ctl.addr = (r_state == S_DUMP) ? r_idx : r_wp;
        w_load   = 1'b0;
        w_ld_a   = w_avg_a;
        w_ld_b   = w_avg_b;
        w_ld_end = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    w_ctl.push = 1'b1;
                    w_ctl.full = w_full;
                    n_wp       = w_wp_nx;
                    n_end      = i_in.run_end;
                    if (w_full) begin
                        // Sliding window: one average, plus h tail copies at run end
                        n_cnt   = i_in.run_end ? CNT_W'(w_h + 1'b1) : CNT_W'(1);
                        n_state = S_PREP;
                    end else if (w_fill_nx == w_w) begin
                        // Window just filled: head copies, or all W at run end
                        n_fill  = w_fill_nx;
                        n_cnt   = i_in.run_end ? w_w : CNT_W'(w_h + 1'b1);
                        n_state = S_PREP;
                    end else begin
                        n_fill = w_fill_nx;
                        if (i_in.run_end) begin
                            // Short run: flush held samples as they are
                            n_cnt       = w_fill_nx;
                            n_idx       = '0;
                            w_ctl.clear = 1'b1;
                            n_state     = S_DUMP;
                        end
                    end
                    if (i_in.run_end) begin
                        n_fill = '0;
                        n_wp   = '0;
                    end
                end
            end
            S_PREP: begin
                // Latch |sum| into the divider, then drop the sum if the run ended
                w_ctl.div_load = 1'b1;
                w_ctl.clear    = r_end;
                n_step         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                w_ctl.div_step = 1'b1;
                n_step         = STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_ld_end = r_end && (r_cnt == CNT_W'(1));
                    n_cnt    = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_ld_a   = w_rd_a;
                    w_ld_b   = w_rd_b;
                    w_ld_end = (r_cnt == CNT_W'(1));
                    n_idx    = WIN_AW'(r_idx + 1'b1);
                    n_cnt    = r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A half-width write drops any partial run
        if (i_cfg_we) begin
            n_fill      = '0;
            n_wp        = '0;
            w_ctl.clear = 1'b1;
        end
    end

    // Hold the result until taken; load the next one as the old one leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oa   <= w_ld_a;
            r_ob   <= w_ld_b;
            r_oend <= w_ld_end;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.smooth_a = r_oa;
    assign o_out.smooth_b = r_ob;
    assign o_out.out_end  = r_oend;

endmodule
